FILE: hw/rtl/pcr_pkg.sv
package pcr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PSX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PSY   = 3'd4;

  localparam logic [15:0] FOCAL_RESET = 16'd10000;
  localparam logic [15:0] PSX_RESET   = 16'd77;
  localparam logic [15:0] PSY_RESET   = 16'd77;

  localparam logic signed [17:0] ANG_PI      = 18'sd51472;
  localparam logic signed [17:0] ANG_HALF_PI = 18'sd25736;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int ATAN_IDX_W = 5;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
  } pcr_in_t;

  typedef struct packed {
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
  } pcr_out_t;

  typedef logic signed [15:0] pcr_q15_t;
  // entries: forward xyz, right xyz, up xyz
  typedef pcr_q15_t [8:0] pcr_basis_t;

  localparam pcr_basis_t BASIS_RESET = {16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                                        16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000};

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ROT,
    BS_MUL,
    BS_WB
  } pcr_bstate_t;

  function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/pcr_basis.sv
module pcr_basis #(
  parameter int SINCOS_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [15:0]   pitch,
  input  logic signed [16:0]   yaw,
  output logic                 busy,
  output pcr_pkg::pcr_basis_t  basis
);
  import pcr_pkg::*;

  localparam int IT_W = $clog2(SINCOS_ITERATIONS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(SINCOS_ITERATIONS - 1);

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } pcr_rot_t;

  pcr_bstate_t state_r, state_nxt;
  logic [IT_W-1:0] it_r;
  logic [1:0] mc_r;
  pcr_rot_t rp_r, ry_r;
  logic pflip_r, yflip_r;
  logic signed [63:0] prod_r;
  logic [1:0] pidx_r;
  logic pv_r;
  pcr_basis_t basis_r;

  logic signed [17:0] pa, ya, pang, yang;
  logic pflip, yflip;
  logic signed [33:0] cx, sx, cy, sy;
  logic signed [31:0] ma, mb;
  logic [29:0] atan_v;

  function automatic pcr_rot_t rot_step(input pcr_rot_t r, input logic [IT_W-1:0] sh,
                                        input logic [29:0] at);
    pcr_rot_t o;
    logic signed [33:0] dx, dy, a;
    dx = r.y >>> sh;
    dy = r.x >>> sh;
    a  = $signed({4'b0000, at});
    if (!r.z[33]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - a;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + a;
    end
    return o;
  endfunction

  function automatic pcr_q15_t q30_round(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] s;
    pcr_q15_t o;
    t = v + 35'sd16384;
    s = t >>> 15;
    if (s > 35'sd32767)       o = 16'sh7FFF;
    else if (s < -35'sd32768) o = 16'sh8000;
    else                      o = s[15:0];
    return o;
  endfunction

  function automatic pcr_q15_t prod_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [63:0] s;
    pcr_q15_t o;
    t = p + (64'sd1 <<< 44);
    s = t >>> 45;
    if (s > 64'sd32767)       o = 16'sh7FFF;
    else if (s < -64'sd32768) o = 16'sh8000;
    else                      o = s[15:0];
    return o;
  endfunction

  // fold angles beyond half pi back toward zero
  always_comb begin
    pa = {{2{pitch[15]}}, pitch};
    ya = {yaw[16], yaw};
    pflip = (pa > ANG_HALF_PI) || (pa < -ANG_HALF_PI);
    yflip = (ya > ANG_HALF_PI) || (ya < -ANG_HALF_PI);
    if (pa > ANG_HALF_PI)       pang = pa - ANG_PI;
    else if (pa < -ANG_HALF_PI) pang = pa + ANG_PI;
    else                        pang = pa;
    if (ya > ANG_HALF_PI)       yang = ya - ANG_PI;
    else if (ya < -ANG_HALF_PI) yang = ya + ANG_PI;
    else                        yang = ya;
    atan_v = atan_q30(ATAN_IDX_W'(it_r));
  end

  always_comb begin
    cx = pflip_r ? -rp_r.x : rp_r.x;
    sx = pflip_r ? -rp_r.y : rp_r.y;
    cy = yflip_r ? -ry_r.x : ry_r.x;
    sy = yflip_r ? -ry_r.y : ry_r.y;
    case (mc_r)
      2'd0: begin ma = cy[31:0]; mb = sx[31:0]; end
      2'd1: begin ma = cy[31:0]; mb = cx[31:0]; end
      2'd2: begin ma = sx[31:0]; mb = sy[31:0]; end
      default: begin ma = cx[31:0]; mb = sy[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy = (state_r != BS_IDLE);
    case (state_r)
      BS_IDLE: begin
        if (start) state_nxt = BS_ROT;
      end
      BS_ROT: begin
        if (it_r == IT_LAST) state_nxt = BS_MUL;
      end
      BS_MUL: begin
        if (mc_r == 2'd3) state_nxt = BS_WB;
      end
      BS_WB: begin
        state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == BS_IDLE && start) begin
      rp_r    <= '{x: CORDIC_GAIN, y: 34'sd0, z: {pang, 16'h0000}};
      ry_r    <= '{x: CORDIC_GAIN, y: 34'sd0, z: {yang, 16'h0000}};
      pflip_r <= pflip;
      yflip_r <= yflip;
      it_r    <= '0;
    end else if (state_r == BS_ROT) begin
      rp_r <= rot_step(rp_r, it_r, atan_v);
      ry_r <= rot_step(ry_r, it_r, atan_v);
      it_r <= it_r + 1'b1;
    end
    if (state_r == BS_MUL) begin
      mc_r <= mc_r + 1'b1;
    end else begin
      mc_r <= 2'd0;
    end
    prod_r <= ma * mb;
    pidx_r <= mc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      basis_r <= BASIS_RESET;
    end else begin
      pv_r <= (state_r == BS_MUL);
      if (state_r == BS_MUL) begin
        basis_r[0] <= q30_round(-sy);
        basis_r[3] <= q30_round(cy);
        basis_r[6] <= 16'sd0;
        basis_r[7] <= q30_round(cx);
        basis_r[8] <= q30_round(-sx);
      end
      if (pv_r) begin
        case (pidx_r)
          2'd0: basis_r[1] <= prod_round(prod_r);
          2'd1: basis_r[2] <= prod_round(prod_r);
          2'd2: basis_r[4] <= prod_round(prod_r);
          default: basis_r[5] <= prod_round(prod_r);
        endcase
      end
    end
  end

  assign basis = basis_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("rebuild did not start");
  a_up_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    basis_r[6] == 16'sd0) else $error("up x entry not zero");
  a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_WB |-> pv_r && pidx_r == 2'd3) else $error("last product not written");
`endif

endmodule

FILE: hw/rtl/pinhole_camera_ray_direction_unit.sv
// channel | direction | beat contents
// in_     | input     | pcr_in_t: pixel_x, pixel_y
// out_    | output    | pcr_out_t: ray_x, ray_y, ray_z
// cfg_    | input     | register index, write data
//
// one beat per cycle while the output is not stalled and no basis rebuild runs
// depth set by the front stages, 31 square-root steps and 16 quotient steps per component
// pitch or yaw write rebuilds the basis (rotate, multiply, write back), no beats taken
// rst_n sync, active low: registers and basis to reset values, pipeline emptied
// out_ready low while a result waits freezes every stage; nothing lost or repeated
module pinhole_camera_ray_direction_unit #(
  parameter int SINCOS_ITERATIONS  = 16,
  parameter int SUBPIXEL_FRAC_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pcr_pkg::pcr_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcr_pkg::pcr_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pcr_pkg::*;

  localparam int TF_W     = 16 + SUBPIXEL_FRAC_BITS;
  localparam int D_W      = 50;
  localparam int M_W      = D_W - 1;
  localparam int P_W      = $clog2(M_W);
  localparam int SQ_W     = 62;
  localparam int SQ_STEPS = 31;
  localparam int DV_W     = 46;
  localparam int Q_W      = 16;

  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } pcr_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } pcr_sign_t;

  logic signed [15:0] pitch_r;
  logic signed [16:0] yaw_r;
  logic [15:0] focal_r, psx_r, psy_r;
  logic start_r;
  logic basis_busy;
  pcr_basis_t basis;
  logic cfg_acc, adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic signed [32:0] tx_r, ty_r;
  logic signed [D_W-1:0] pr_r [0:8];
  logic signed [D_W-1:0] d_r [0:2];
  logic [M_W-1:0] mag4_r [0:2];
  logic [2:0] neg4_r, neg5_r, neg6_r;
  logic [M_W-1:0] mag5_r [0:2];
  logic [M_W-1:0] mag6_r [0:2];
  logic [M_W-1:0] m5_r;
  logic [P_W-1:0] p6_r;
  logic z6_r;
  pcr_side_t s7_r, s8_r;
  logic [2:0][59:0] sq8_r;

  logic iv_r [0:SQ_STEPS];
  logic [SQ_W-1:0] sn_r [0:SQ_STEPS];
  logic [SQ_W-1:0] sr_r [0:SQ_STEPS];
  pcr_side_t side_r [0:SQ_STEPS];

  logic dv_r [0:Q_W];
  logic [2:0][DV_W-1:0] dn_r [0:Q_W];
  logic [2:0][Q_W-1:0] dq_r [0:Q_W];
  logic [30:0] dl_r [0:Q_W];
  pcr_sign_t dside_r [0:Q_W];

  logic out_valid_r;
  pcr_out_t out_data_r;

  logic [TF_W-1:0] tf;
  logic signed [TF_W:0] tf_s;
  logic [M_W-1:0] m5_nxt;
  logic [P_W-1:0] p6_nxt;
  pcr_side_t s7_nxt;
  logic [30:0] len;
  logic [2:0][15:0] ray;

  assign adv       = !out_valid_r || out_ready;
  assign cfg_ready = !start_r && !basis_busy;
  assign in_ready  = adv && !start_r && !basis_busy;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= 16'sd0;
      yaw_r   <= 17'sd0;
      focal_r <= FOCAL_RESET;
      psx_r   <= PSX_RESET;
      psy_r   <= PSY_RESET;
      start_r <= 1'b0;
    end else begin
      start_r <= cfg_acc && (cfg_index == REG_PITCH || cfg_index == REG_YAW);
      if (cfg_acc) begin
        case (cfg_index)
          REG_PITCH: pitch_r <= cfg_data[15:0];
          REG_YAW:   yaw_r   <= cfg_data;
          REG_FOCAL: focal_r <= cfg_data[15:0];
          REG_PSX:   psx_r   <= cfg_data[15:0];
          REG_PSY:   psy_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  pcr_basis #(
    .SINCOS_ITERATIONS(SINCOS_ITERATIONS)
  ) u_basis (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .pitch (pitch_r),
    .yaw   (yaw_r),
    .busy  (basis_busy),
    .basis (basis)
  );

  // front stages
  always_comb begin
    tf   = TF_W'(focal_r) << SUBPIXEL_FRAC_BITS;
    tf_s = $signed({1'b0, tf});
    m5_nxt = mag4_r[0];
    if (mag4_r[1] > m5_nxt) m5_nxt = mag4_r[1];
    if (mag4_r[2] > m5_nxt) m5_nxt = mag4_r[2];
    p6_nxt = '0;
    for (int b = 0; b < M_W; b++) begin
      if (m5_r[b]) p6_nxt = P_W'(b);
    end
    s7_nxt.neg  = neg6_r;
    s7_nxt.zero = z6_r;
    for (int k = 0; k < 3; k++) begin
      if (p6_r >= P_W'(29)) begin
        s7_nxt.mag[k] = 30'(mag6_r[k] >> (p6_r - P_W'(29)));
      end else begin
        s7_nxt.mag[k] = 30'(mag6_r[k] << (P_W'(29) - p6_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      iv_r[0] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid && in_ready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      iv_r[0] <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= $signed({1'b0, psx_r}) * in_data.pixel_x;
      ty_r <= $signed({1'b0, psy_r}) * in_data.pixel_y;
      for (int k = 0; k < 3; k++) begin
        pr_r[k]     <= $signed(basis[k]) * tf_s;
        pr_r[3 + k] <= $signed(basis[3 + k]) * tx_r;
        pr_r[6 + k] <= $signed(basis[6 + k]) * ty_r;
        d_r[k]      <= pr_r[k] + pr_r[3 + k] + pr_r[6 + k];
        neg4_r[k]   <= d_r[k][D_W-1];
        mag4_r[k]   <= d_r[k][D_W-1] ? M_W'(-d_r[k]) : M_W'(d_r[k]);
        mag5_r[k]   <= mag4_r[k];
        mag6_r[k]   <= mag5_r[k];
        sq8_r[k]    <= s7_r.mag[k] * s7_r.mag[k];
      end
      neg5_r <= neg4_r;
      m5_r   <= m5_nxt;
      neg6_r <= neg5_r;
      p6_r   <= p6_nxt;
      z6_r   <= (m5_r == '0);
      s7_r   <= s7_nxt;
      s8_r   <= s7_r;
      sn_r[0]   <= SQ_W'(sq8_r[0]) + SQ_W'(sq8_r[1]) + SQ_W'(sq8_r[2]);
      sr_r[0]   <= '0;
      side_r[0] <= s8_r;
    end
  end

  // integer square root, one result bit per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    localparam logic [SQ_W:0] SBIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * g);
    logic [SQ_W:0] trial;
    logic take;

    assign trial = {1'b0, sr_r[g]} + SBIT;
    assign take  = ({1'b0, sn_r[g]} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        iv_r[g + 1] <= 1'b0;
      end else if (adv) begin
        iv_r[g + 1] <= iv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sn_r[g + 1]   <= take ? sn_r[g] - trial[SQ_W-1:0] : sn_r[g];
        sr_r[g + 1]   <= take ? (sr_r[g] >> 1) + SBIT[SQ_W-1:0] : sr_r[g] >> 1;
        side_r[g + 1] <= side_r[g];
      end
    end
  end

  assign len = sr_r[SQ_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= iv_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dn_r[0][k] <= (DV_W'(side_r[SQ_STEPS].mag[k]) << 15) + DV_W'(len >> 1);
      end
      dq_r[0]         <= '0;
      dl_r[0]         <= len;
      dside_r[0].neg  <= side_r[SQ_STEPS].neg;
      dside_r[0].zero <= side_r[SQ_STEPS].zero;
    end
  end

  // rounded quotient, one bit per stage, msb first
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int SH = Q_W - 1 - j;
    logic [DV_W:0] sub;
    logic [2:0] take;
    logic [2:0][DV_W-1:0] rem_nxt;

    always_comb begin
      sub = (DV_W + 1)'(dl_r[j]) << SH;
      for (int k = 0; k < 3; k++) begin
        take[k]    = ({1'b0, dn_r[j][k]} >= sub);
        rem_nxt[k] = take[k] ? dn_r[j][k] - sub[DV_W-1:0] : dn_r[j][k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j + 1] <= 1'b0;
      end else if (adv) begin
        dv_r[j + 1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          dq_r[j + 1][k] <= {dq_r[j][k][Q_W-2:0], take[k]};
        end
        dn_r[j + 1]    <= rem_nxt;
        dl_r[j + 1]    <= dl_r[j];
        dside_r[j + 1] <= dside_r[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dside_r[Q_W].zero) begin
        ray[k] = 16'h0000;
      end else if (dside_r[Q_W].neg[k]) begin
        ray[k] = 16'(17'd0 - {1'b0, dq_r[Q_W][k]});
      end else if (dq_r[Q_W][k][15]) begin
        ray[k] = 16'h7FFF;
      end else begin
        ray[k] = dq_r[Q_W][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.ray_x <= ray[0];
      out_data_r.ray_y <= ray[1];
      out_data_r.ray_z <= ray[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] && !dside_r[0].zero |-> dl_r[0][30:29] != 2'b00)
    else $error("length out of normalized range");
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[Q_W] && !dside_r[Q_W].zero |->
      dq_r[Q_W][0] <= 16'd32768 && dq_r[Q_W][1] <= 16'd32768 &&
      dq_r[Q_W][2] <= 16'd32768)
    else $error("quotient above unit");
  a_angle_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_PITCH || cfg_index == REG_YAW) |=>
      !in_ready)
    else $error("beat taken during basis rebuild");
`endif

endmodule
